### rtl/ffhf_pkg.sv
// ----------------------------------------------------------------------------
// ffhf_pkg
// Shared types and constants for the fixed-length header/footer frame sync.
// ----------------------------------------------------------------------------
package ffhf_pkg;

	localparam int BYTE_W             = 8;
	localparam int PACKET_BYTES_DEF   = 16;
	localparam int HEADER_BYTES_DEF   = 2;
	localparam int FOOTER_BYTES_DEF   = 2;
	localparam int PATTERN_W          = 32;
	localparam int QUEUE_DEPTH        = 2;

	localparam int CFG_AW             = 3;
	localparam int CFG_DW             = 32;

	typedef enum logic [0:0] {
		REG_HEADER = 1'b0,
		REG_FOOTER = 1'b1
	} cfg_reg_t;

endpackage

### rtl/ffhf_front.sv
// ----------------------------------------------------------------------------
// ffhf_front
// Byte window, fresh-byte count and header/footer match; pushes whole frames.
// ----------------------------------------------------------------------------
module ffhf_front
	import ffhf_pkg::*;
#(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int FOOTER_BYTES = FOOTER_BYTES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    rx_valid,
	output logic                                    rx_stall,
	input  logic [BYTE_W-1:0]                       rx_byte,
	input  logic [PATTERN_W-1:0]                    header_pattern,
	input  logic [PATTERN_W-1:0]                    footer_pattern,
	input  logic                                    q_full,
	output logic                                    q_push,
	output logic [PACKET_BYTES-1:0][BYTE_W-1:0]     q_push_frame
);

	localparam int CW = $clog2(PACKET_BYTES + 1);

	logic [PACKET_BYTES-1:0][BYTE_W-1:0] win_q;
	logic [PACKET_BYTES-1:0][BYTE_W-1:0] win_nxt;
	logic [CW-1:0]                       cnt_q;
	logic [CW-1:0]                       cnt_nxt;
	logic                                accept;
	logic                                hit;

	assign rx_stall = q_full;
	assign accept   = rx_valid & ~q_full;

	// index 0 is the oldest byte
	assign win_nxt = {rx_byte, win_q[PACKET_BYTES-1:1]};
	assign cnt_nxt = (cnt_q == CW'(PACKET_BYTES)) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		hit = (cnt_nxt == CW'(PACKET_BYTES));
		for (int k = 0; k < HEADER_BYTES; k++) begin
			if (win_nxt[k] != header_pattern[BYTE_W*k +: BYTE_W])
				hit = 1'b0;
		end
		for (int k = 0; k < FOOTER_BYTES; k++) begin
			if (win_nxt[PACKET_BYTES-FOOTER_BYTES+k] != footer_pattern[BYTE_W*k +: BYTE_W])
				hit = 1'b0;
		end
	end

	assign q_push       = accept & hit;
	assign q_push_frame = win_nxt;

	always_ff @(posedge clk) begin
		if (accept)
			win_q <= win_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= hit ? '0 : cnt_nxt;
		end
	end

endmodule

### rtl/ffhf_queue.sv
// ----------------------------------------------------------------------------
// ffhf_queue
// Short queue of complete frames between the match front and the streamer.
// ----------------------------------------------------------------------------
module ffhf_queue
	import ffhf_pkg::*;
#(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [PACKET_BYTES-1:0][BYTE_W-1:0] push_frame,
	output logic                                full,
	input  logic                                pop,
	output logic [PACKET_BYTES-1:0][BYTE_W-1:0] pop_frame,
	output logic                                nonempty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [QUEUE_DEPTH-1:0][PACKET_BYTES-1:0][BYTE_W-1:0] mem_q;
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;

	assign full      = (fill_q == NW'(QUEUE_DEPTH));
	assign nonempty  = (fill_q != '0);
	assign pop_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

### rtl/ffhf_back.sv
// ----------------------------------------------------------------------------
// ffhf_back
// Streams one queued frame out a byte at a time through an output register.
// ----------------------------------------------------------------------------
module ffhf_back
	import ffhf_pkg::*;
#(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_nonempty,
	input  logic [PACKET_BYTES-1:0][BYTE_W-1:0] q_frame,
	output logic                                q_pop,
	output logic                                frame_valid,
	input  logic                                frame_stall,
	output logic [BYTE_W-1:0]                   frame_byte,
	output logic                                frame_last
);

	localparam int IW = $clog2(PACKET_BYTES);

	logic [PACKET_BYTES-1:0][BYTE_W-1:0] sh_q;
	logic [IW-1:0]                       idx_q;
	logic                                busy_q;
	logic                                out_valid_q;
	logic [BYTE_W-1:0]                   out_byte_q;
	logic                                out_last_q;
	logic                                adv;

	assign adv   = ~out_valid_q | ~frame_stall;
	assign q_pop = q_nonempty & ~busy_q;

	assign frame_valid = out_valid_q;
	assign frame_byte  = out_byte_q;
	assign frame_last  = out_last_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sh_q <= q_frame;
		end else if (busy_q && adv) begin
			sh_q <= {BYTE_W'(0), sh_q[PACKET_BYTES-1:1]};
		end
		if (busy_q && adv) begin
			out_byte_q <= sh_q[0];
			out_last_q <= (idx_q == IW'(PACKET_BYTES - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv)
				out_valid_q <= busy_q;
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q && adv) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == IW'(PACKET_BYTES - 1))
					busy_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/fixed_frame_header_footer_sync.sv
// ----------------------------------------------------------------------------
// fixed_frame_header_footer_sync
// Finds fixed-length frames with a configured header and footer in a byte
// stream and streams each frame out with its final byte marked.
// ----------------------------------------------------------------------------
// Usage:
//  rx channel (rx_valid/rx_stall/rx_byte) takes one received byte per request.
//  frame channel (frame_valid/frame_stall/frame_byte/frame_last) gives the
//  bytes of each matched frame, oldest first, frame_last on the final byte.
//  APB port: header_pattern at 0x0, footer_pattern at 0x4; write while idle.
// Timing:
//  One rx byte is taken every cycle; the front holds a byte only while the
//  two-frame queue is full. After its closing rx byte, a frame moves through
//  the queue, the streamer's shift register and the output register; the
//  streamer reloads from the queue once the frame's last byte is registered.
// Reset:
//  Clears the fresh-byte count, queue and streamer; patterns reset to zero.
// Receiver stall:
//  The output register holds; the queue absorbs up to two matched frames,
//  after which rx_stall rises.
// ----------------------------------------------------------------------------
module fixed_frame_header_footer_sync
	import ffhf_pkg::*;
#(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int FOOTER_BYTES = FOOTER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              frame_valid,
	input  logic              frame_stall,
	output logic [BYTE_W-1:0] frame_byte,
	output logic              frame_last
);

	logic [PATTERN_W-1:0]                header_q;
	logic [PATTERN_W-1:0]                footer_q;
	cfg_reg_t                            reg_sel;
	logic                                q_push;
	logic [PACKET_BYTES-1:0][BYTE_W-1:0] q_push_frame;
	logic                                q_full;
	logic                                q_pop;
	logic [PACKET_BYTES-1:0][BYTE_W-1:0] q_pop_frame;
	logic                                q_nonempty;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[2]);

	always_comb begin
		unique case (reg_sel)
			REG_HEADER: prdata = header_q;
			REG_FOOTER: prdata = footer_q;
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			footer_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_HEADER: header_q <= pwdata;
				REG_FOOTER: footer_q <= pwdata;
				default: ;
			endcase
		end
	end

	ffhf_front #(
		.PACKET_BYTES (PACKET_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.FOOTER_BYTES (FOOTER_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.header_pattern (header_q),
		.footer_pattern (footer_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_push_frame   (q_push_frame)
	);

	ffhf_queue #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_frame (q_push_frame),
		.full       (q_full),
		.pop        (q_pop),
		.pop_frame  (q_pop_frame),
		.nonempty   (q_nonempty)
	);

	ffhf_back #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_frame     (q_pop_frame),
		.q_pop       (q_pop),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last)
	);

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("frame pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty)
		else $error("frame popped from empty queue");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && frame_stall) |=>
			(frame_valid && $stable(frame_byte) && $stable(frame_last)))
		else $error("stalled frame request changed");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams received bytes into the header/footer frame sync: a directed
// frame first, then random phases of frames, broken frames and noise under
// several pattern settings. A software frame finder predicts every emitted
// byte and its last flag; beats are compared in order as they leave.
// ----------------------------------------------------------------------------
module testbench
	import ffhf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PKT     = PACKET_BYTES_DEF;
	localparam int HDR     = HEADER_BYTES_DEF;
	localparam int FTR     = FOOTER_BYTES_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} frame_beat_t;

	class frame_scoreboard;
		logic [BYTE_W-1:0]    window[PKT];
		int unsigned          fresh;
		logic [PATTERN_W-1:0] header_pat;
		logic [PATTERN_W-1:0] footer_pat;
		frame_beat_t          pending[$];
		int unsigned          errors;
		int unsigned          bytes_in;
		int unsigned          frames_out;

		function new();
			foreach (window[i]) window[i] = '0;
			fresh = 0;
			header_pat = '0;
			footer_pat = '0;
			errors = 0;
			bytes_in = 0;
			frames_out = 0;
		endfunction

		function void set_pattern(cfg_reg_t r, logic [PATTERN_W-1:0] v);
			if (r == REG_HEADER) header_pat = v;
			else footer_pat = v;
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10)
				$display("ERROR %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
		endfunction

		function bit frame_found();
			for (int k = 0; k < HDR; k++)
				if (window[k] != header_pat[8*k +: 8]) return 1'b0;
			for (int k = 0; k < FTR; k++)
				if (window[PKT-FTR+k] != footer_pat[8*k +: 8]) return 1'b0;
			return 1'b1;
		endfunction

		function void note_rx(logic [BYTE_W-1:0] b);
			frame_beat_t beat;
			bytes_in++;
			for (int i = 0; i < PKT-1; i++) window[i] = window[i+1];
			window[PKT-1] = b;
			if (fresh < PKT) fresh++;
			if (fresh >= PKT && frame_found()) begin
				for (int i = 0; i < PKT; i++) begin
					beat.data = window[i];
					beat.last = (i == PKT-1);
					pending.push_back(beat);
				end
				fresh = 0;
			end
		endfunction

		function void check_beat(logic [BYTE_W-1:0] d, logic l);
			frame_beat_t want;
			if (pending.size() == 0) begin
				flag("unexpected frame byte", 32'h0, {23'h0, l, d});
				return;
			end
			want = pending.pop_front();
			if (d !== want.data) flag("frame_byte", want.data, d);
			if (l !== want.last) flag("frame_last", want.last, l);
			if (want.last) frames_out++;
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic              pready;
	logic              rx_valid = 1'b0;
	logic              rx_stall;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              frame_valid;
	logic              frame_stall = 1'b0;
	logic [BYTE_W-1:0] frame_byte;
	logic              frame_last;

	frame_scoreboard sb = new();
	bit          calm = 1'b0;
	int unsigned hold_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned backpressure = 0;
	int unsigned settings = 0;

	fixed_frame_header_footer_sync u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && frame_valid && !frame_stall)
			sb.check_beat(frame_byte, frame_last);
	end

	// receiver side: random stalls plus rare long holds to fill the frame queue
	always @(posedge clk) begin
		if (calm) begin
			frame_stall <= 1'b0;
		end else if (hold_left != 0) begin
			frame_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			frame_stall <= ($urandom_range(99) < 24);
			if ($urandom_range(999) == 0) hold_left <= $urandom_range(40, 120);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && rx_stall) backpressure++;
			if ((rx_valid && !rx_stall) || (frame_valid && !frame_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic apb_access(input cfg_reg_t r, input bit wr, input logic [CFG_DW-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= CFG_AW'(4 * int'(r));
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata !== v) sb.flag("register readback", v, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_patterns(input logic [PATTERN_W-1:0] hp, input logic [PATTERN_W-1:0] fp);
		apb_access(REG_HEADER, 1'b1, hp);
		apb_access(REG_FOOTER, 1'b1, fp);
		sb.set_pattern(REG_HEADER, hp);
		sb.set_pattern(REG_FOOTER, fp);
		apb_access(REG_HEADER, 1'b0, hp);
		apb_access(REG_FOOTER, 1'b0, fp);
		settings++;
	endtask

	task automatic push_rx(input logic [BYTE_W-1:0] b);
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		sb.note_rx(b);
		if (!calm) begin
			while ($urandom_range(99) < 24) begin
				rx_valid <= 1'b0;
				rx_byte <= BYTE_W'($urandom_range(255));
				@(posedge clk);
			end
		end
	endtask

	// frame body byte: often a header or footer byte to tempt false syncs
	function automatic logic [BYTE_W-1:0] body_byte();
		unique case ($urandom_range(5))
			0: return sb.header_pat[8*$urandom_range(HDR-1) +: 8];
			1: return sb.footer_pat[8*$urandom_range(FTR-1) +: 8];
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	task automatic push_frame(input bit broken);
		logic [BYTE_W-1:0] pkt[PKT];
		int                bad;
		for (int i = 0; i < PKT; i++) pkt[i] = body_byte();
		for (int k = 0; k < HDR; k++) pkt[k] = sb.header_pat[8*k +: 8];
		for (int k = 0; k < FTR; k++) pkt[PKT-FTR+k] = sb.footer_pat[8*k +: 8];
		if (broken) begin
			bad = $urandom_range(HDR + FTR - 1);
			bad = (bad < HDR) ? bad : PKT - FTR + (bad - HDR);
			pkt[bad] = pkt[bad] ^ (8'h01 << $urandom_range(7));
		end
		for (int i = 0; i < PKT; i++) push_rx(pkt[i]);
	endtask

	task automatic wait_idle();
		rx_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned budget);
		int unsigned start;
		int unsigned pick;
		start = sb.bytes_in;
		while (sb.bytes_in - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				push_frame(1'b0);
			end else if (pick < 80) begin
				push_frame(1'b1);
			end else begin
				repeat ($urandom_range(1, 5)) push_rx(body_byte());
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unused pattern bytes set, noise ahead of a frame, extreme bytes
		set_patterns(32'hDEAD_55AA, 32'hBEEF_0D0A);
		push_rx(8'h00);
		push_rx(8'hFF);
		push_rx(8'hAA);
		push_rx(8'hAA);
		push_rx(8'h55);
		push_rx(8'h00);
		push_rx(8'hFF);
		for (int i = 0; i < PKT - HDR - FTR - 2; i++) push_rx(8'h01 << (i % 8));
		push_rx(8'h0A);
		push_rx(8'h0D);
		push_rx(8'h0A);
		wait_idle();

		set_patterns(32'h0000_0000, 32'h0000_0000);
		random_phase(70);
		wait_idle();

		calm = 1'b1;
		set_patterns(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_phase(70);
		wait_idle();
		calm = 1'b0;

		set_patterns($urandom, $urandom);
		random_phase(80);
		wait_idle();

		pick_same: begin
			logic [PATTERN_W-1:0] p;
			p = $urandom;
			set_patterns(p, p);
		end
		random_phase(80);
		wait_idle();

		$display("run: %0d rx bytes, %0d frames checked, %0d pattern settings",
			sb.bytes_in, sb.frames_out, settings);
		$display("run: rx held off on %0d cycles, %0d mismatches", backpressure, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
